FILE: hw/rtl/lus_pkg.sv
package lus_pkg;

    // Request codes carried in tuser of an input word.
    typedef enum logic [1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_SOLVE   = 2'd2,
        MODE_FACTOR  = 2'd3
    } t_mode;

    // Which group of elements the sequencer is computing.
    typedef enum logic [1:0] {
        PH_LOWER,
        PH_UPPER,
        PH_FORWARD,
        PH_BACKWARD
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_MUL,
        ST_PROD,
        ST_SUB,
        ST_END,
        ST_DIV,
        ST_DIV_DONE,
        ST_NEXT,
        ST_PIVOT,
        ST_OUT
    } t_state;

    // Magnitudes are split into two halves of this width for the shared multiplier.
    localparam int SPLIT_W = 24;
    localparam int PROD_W  = 2 * SPLIT_W;
    // Width that holds the recombined partial products before saturation.
    localparam int SUM_W   = PROD_W + 2;

endpackage

FILE: hw/rtl/lu_solve_4x4.sv
// Solves a 4x4 system A x = b in signed fixed point (VALUE_WIDTH bits, FRAC_BITS
// fraction bits, Q16.16 by default). Each input word either loads one entry of A
// or b (no result), requests a solve (four result words, index 0..3), or requests
// the packed Crout LU factors (sixteen result words, index row*4+col, L on and
// below the diagonal, U with its unit diagonal strictly above it). No pivoting is
// done; a zero pivot makes every result word of that run zero with the singular
// flag set. All arithmetic runs on one shared 24x24 multiplier (four passes per
// product) and one radix-2 divider that yields a VALUE_WIDTH+FRAC_BITS bit
// quotient. When a run ends, the results stream out at one word per cycle while
// the receiver is ready. The input is not ready while a run is in progress.
module lu_solve_4x4
    import lus_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // row[1:0], col[3:2], value[35:4], zero[39:36]
    input  logic [39:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // index[3:0], result_value[35:4], zero[39:36]
    output logic [39:0] o_m_axis_tdata,
    // singular[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    localparam int VW  = VALUE_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int EW  = (VW > 32) ? VW : 32;
    localparam int AW  = EW + 4;
    localparam int DW  = VW + FB;
    localparam int MX  = (DW > SUM_W) ? DW : SUM_W;
    localparam int CW  = $clog2(DW);
    localparam int HS  = VW - 1 + FB - PROD_W;
    localparam int HSC = (HS < 0) ? 0 : HS;

    localparam logic [PROD_W-1:0] HI_LIM  = (HS < 0) ? '0 : (PROD_W'(1) << HSC);
    localparam logic [PROD_W:0]   MID_LIM = (PROD_W + 1)'(1) << (VW + FB - SPLIT_W - 1);
    localparam logic [MX-1:0]     MAG_LIM = MX'(1) << (VW - 1);
    localparam logic signed [VW-1:0] VMAX_V = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN_V = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [AW-1:0] VMAX_A = {{(AW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [AW-1:0] VMIN_A = ~VMAX_A;
    localparam logic signed [AW-1:0] OMAX_A = {{(AW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [AW-1:0] OMIN_A = ~OMAX_A;
    localparam logic [CW-1:0]        DIV_LAST = CW'(DW - 1);

    // Saturate a wide signed value to the working width.
    function automatic logic signed [VW-1:0] f_sat(input logic signed [AW-1:0] a);
        if (a > VMAX_A) begin
            return VMAX_V;
        end else if (a < VMIN_A) begin
            return VMIN_V;
        end
        return a[VW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] f_ext(input logic signed [VW-1:0] v);
        return {{(AW-VW){v[VW-1]}}, v};
    endfunction

    function automatic logic [VW-1:0] f_mag(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] ng;
        ng = -v;
        return v[VW-1] ? ng : v;
    endfunction

    // Apply a sign to a magnitude, clamping to the working range.
    function automatic logic signed [VW-1:0] f_signed(input logic [MX-1:0] m,
                                                      input logic neg);
        logic [MX-1:0] mc;
        logic [MX-1:0] mn;
        mc = (m > MAG_LIM) ? MAG_LIM : m;
        mn = -mc;
        if (neg) begin
            return mn[VW-1:0];
        end else if (mc == MAG_LIM) begin
            return VMAX_V;
        end
        return mc[VW-1:0];
    endfunction

    // Stores.
    logic signed [VW-1:0] r_mat [16];
    logic signed [VW-1:0] r_rhs [4];
    logic signed [VW-1:0] r_fac [16];
    logic signed [VW-1:0] r_vec [4];

    // Control and datapath registers.
    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [1:0]           r_j, n_j, r_i, n_i, r_k, n_k;
    logic                 r_solve, n_solve;
    logic                 r_sing, n_sing;
    logic                 r_neg, n_neg;
    logic signed [AW-1:0] r_acc, n_acc;
    logic [VW-1:0]        r_ma, n_ma, r_mb, n_mb;
    logic [1:0]           r_pp, n_pp;
    logic [PROD_W-1:0]    r_hi, n_hi, r_lo, n_lo;
    logic [PROD_W:0]      r_mid, n_mid;
    logic signed [VW-1:0] r_prod, n_prod;
    logic [VW-1:0]        r_md, n_md, r_rem, n_rem;
    logic [DW-1:0]        r_dq, n_dq;
    logic [CW-1:0]        r_dcnt, n_dcnt;
    logic [3:0]           r_oidx, n_oidx;
    logic                 r_ovalid, n_ovalid;
    logic [3:0]           r_oindex, n_oindex;
    logic [31:0]          r_ovalue, n_ovalue;
    logic                 r_osing, n_osing, r_olast, n_olast;

    // Store write controls.
    logic                 mat_we, rhs_we, fac_we, vec_we;
    logic [3:0]           fac_wa;
    logic signed [VW-1:0] wr_data;

    // Job addressing.
    logic [3:0]           a_addr, b_addr, div_addr, dst_addr, fac_ra;
    logic signed [VW-1:0] fac_rd, b_val, base_val;
    logic                 has_terms, last_term, use_div, dst_fac;
    logic [1:0]           k_start;

    // Input fields.
    t_mode                in_mode;
    logic [1:0]           in_row, in_col;
    logic signed [31:0]   in_value;
    logic                 in_acc;

    // Shared multiplier and divider step.
    logic [SPLIT_W-1:0]   mul_x, mul_y;
    logic [PROD_W-1:0]    mul_p;
    logic [VW:0]          trial;
    logic                 trial_ge;

    assign in_mode  = t_mode'(i_s_axis_tuser);
    assign in_row   = i_s_axis_tdata[1:0];
    assign in_col   = i_s_axis_tdata[3:2];
    assign in_value = i_s_axis_tdata[35:4];
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {4'd0, r_ovalue, r_oindex};
    assign o_m_axis_tuser  = r_osing;
    assign o_m_axis_tlast  = r_olast;

    // Operand addresses and bounds of the element being computed.
    always_comb begin
        a_addr    = {r_i, r_k};
        b_addr    = {r_k, r_j};
        div_addr  = {r_i, r_i};
        dst_addr  = {r_i, r_j};
        base_val  = r_mat[{r_i, r_j}];
        has_terms = (r_j != 2'd0);
        last_term = (r_k == r_j - 2'd1);
        k_start   = 2'd0;
        use_div   = 1'b0;
        dst_fac   = 1'b1;
        case (r_phase)
            PH_LOWER: begin
            end
            PH_UPPER: begin
                a_addr   = {r_j, r_k};
                b_addr   = {r_k, r_i};
                div_addr = {r_j, r_j};
                dst_addr = {r_j, r_i};
                base_val = r_mat[{r_j, r_i}];
                use_div  = 1'b1;
            end
            PH_FORWARD: begin
                base_val  = r_rhs[r_i];
                has_terms = (r_i != 2'd0);
                last_term = (r_k == r_i - 2'd1);
                use_div   = 1'b1;
                dst_fac   = 1'b0;
            end
            PH_BACKWARD: begin
                base_val  = r_vec[r_i];
                has_terms = (r_i != 2'd3);
                last_term = (r_k == 2'd3);
                k_start   = r_i + 2'd1;
                dst_fac   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Single read port of the factor store.
    always_comb begin
        case (r_state)
            ST_FETCH_A:  fac_ra = a_addr;
            ST_FETCH_B:  fac_ra = b_addr;
            ST_END:      fac_ra = div_addr;
            ST_PIVOT:    fac_ra = {r_j, r_j};
            ST_OUT:      fac_ra = r_oidx;
            default:     fac_ra = a_addr;
        endcase
    end
    assign fac_rd = r_fac[fac_ra];
    assign b_val  = (r_phase == PH_LOWER || r_phase == PH_UPPER) ? fac_rd : r_vec[r_k];

    // One partial product of the split magnitudes per cycle.
    always_comb begin
        case (r_pp)
            2'd0: begin
                mul_x = SPLIT_W'(PROD_W'(r_ma) >> SPLIT_W);
                mul_y = SPLIT_W'(PROD_W'(r_mb) >> SPLIT_W);
            end
            2'd1: begin
                mul_x = SPLIT_W'(PROD_W'(r_ma) >> SPLIT_W);
                mul_y = SPLIT_W'(r_mb);
            end
            2'd2: begin
                mul_x = SPLIT_W'(r_ma);
                mul_y = SPLIT_W'(PROD_W'(r_mb) >> SPLIT_W);
            end
            default: begin
                mul_x = SPLIT_W'(r_ma);
                mul_y = SPLIT_W'(r_mb);
            end
        endcase
        mul_p = mul_x * mul_y;
    end

    // Restoring divider step.
    assign trial    = {r_rem, r_dq[DW-1]};
    assign trial_ge = (trial >= {1'b0, r_md});

    // Sequencer: next state and datapath updates.
    always_comb begin
        logic signed [VW-1:0] sacc;
        logic signed [VW-1:0] outv;
        logic signed [AW-1:0] outx;
        logic [VW:0]          diff;
        logic [MX-1:0]        msum;
        logic                 ovf;

        n_state  = r_state;
        n_phase  = r_phase;
        n_j      = r_j;
        n_i      = r_i;
        n_k      = r_k;
        n_solve  = r_solve;
        n_sing   = r_sing;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_pp     = r_pp;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_lo     = r_lo;
        n_prod   = r_prod;
        n_md     = r_md;
        n_rem    = r_rem;
        n_dq     = r_dq;
        n_dcnt   = r_dcnt;
        n_oidx   = r_oidx;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_oindex = r_oindex;
        n_ovalue = r_ovalue;
        n_osing  = r_osing;
        n_olast  = r_olast;
        mat_we   = 1'b0;
        rhs_we   = 1'b0;
        fac_we   = 1'b0;
        vec_we   = 1'b0;
        fac_wa   = dst_addr;
        wr_data  = f_sat({{(AW-32){in_value[31]}}, in_value});

        sacc = f_sat(r_acc);
        diff = trial - {1'b0, r_md};
        ovf  = (r_hi > HI_LIM) || (r_mid > MID_LIM);
        msum = (MX'(r_hi) << (PROD_W - FB)) + (MX'(r_mid) << (SPLIT_W - FB))
             + MX'(r_lo >> FB);
        outv = r_solve ? r_vec[r_oidx[1:0]] : fac_rd;
        outx = f_ext(outv);

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_mode)
                        MODE_LOAD_A: mat_we = 1'b1;
                        MODE_LOAD_B: rhs_we = 1'b1;
                        MODE_SOLVE, MODE_FACTOR: begin
                            n_solve = (in_mode == MODE_SOLVE);
                            n_phase = PH_LOWER;
                            n_j     = 2'd0;
                            n_i     = 2'd0;
                            n_sing  = 1'b0;
                            n_state = ST_BASE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BASE: begin
                n_acc   = f_ext(base_val);
                n_k     = k_start;
                n_state = has_terms ? ST_FETCH_A : ST_END;
            end
            ST_FETCH_A: begin
                n_ma    = f_mag(fac_rd);
                n_neg   = fac_rd[VW-1];
                n_state = ST_FETCH_B;
            end
            ST_FETCH_B: begin
                n_mb    = f_mag(b_val);
                n_neg   = r_neg ^ b_val[VW-1];
                n_pp    = 2'd0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                case (r_pp)
                    2'd0: n_hi  = mul_p;
                    2'd1: n_mid = {1'b0, mul_p};
                    2'd2: n_mid = r_mid + {1'b0, mul_p};
                    default: n_lo = mul_p;
                endcase
                n_pp = r_pp + 2'd1;
                if (r_pp == 2'd3) begin
                    n_state = ST_PROD;
                end
            end
            ST_PROD: begin
                n_prod  = f_signed(ovf ? MAG_LIM : msum, r_neg);
                n_state = ST_SUB;
            end
            ST_SUB: begin
                n_acc = r_acc - f_ext(r_prod);
                if (last_term) begin
                    n_state = ST_END;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_FETCH_A;
                end
            end
            ST_END: begin
                if (use_div) begin
                    n_md    = f_mag(fac_rd);
                    n_neg   = sacc[VW-1] ^ fac_rd[VW-1];
                    n_dq    = {f_mag(sacc), {FB{1'b0}}};
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_state = ST_DIV;
                end else begin
                    wr_data = sacc;
                    fac_we  = dst_fac;
                    vec_we  = !dst_fac;
                    n_state = ST_NEXT;
                end
            end
            ST_DIV: begin
                n_rem  = trial_ge ? diff[VW-1:0] : trial[VW-1:0];
                n_dq   = {r_dq[DW-2:0], trial_ge};
                n_dcnt = r_dcnt + CW'(1);
                if (r_dcnt == DIV_LAST) begin
                    n_state = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE: begin
                wr_data = (r_md == '0) ? '0 : f_signed(MX'(r_dq), r_neg);
                fac_we  = dst_fac;
                vec_we  = !dst_fac;
                n_state = ST_NEXT;
            end
            ST_NEXT: begin
                n_state = ST_BASE;
                case (r_phase)
                    PH_LOWER: begin
                        if (r_i != 2'd3) begin
                            n_i = r_i + 2'd1;
                        end else begin
                            n_state = ST_PIVOT;
                        end
                    end
                    PH_UPPER: begin
                        if (r_i != 2'd3) begin
                            n_i = r_i + 2'd1;
                        end else begin
                            n_j     = r_j + 2'd1;
                            n_i     = r_j + 2'd1;
                            n_phase = PH_LOWER;
                        end
                    end
                    PH_FORWARD: begin
                        if (r_i != 2'd3) begin
                            n_i = r_i + 2'd1;
                        end else begin
                            n_phase = PH_BACKWARD;
                        end
                    end
                    default: begin
                        if (r_i != 2'd0) begin
                            n_i = r_i - 2'd1;
                        end else begin
                            n_oidx  = '0;
                            n_state = ST_OUT;
                        end
                    end
                endcase
            end
            ST_PIVOT: begin
                // A zero diagonal entry of L ends the factorization.
                if (fac_rd == '0) begin
                    n_sing  = 1'b1;
                    n_oidx  = '0;
                    n_state = ST_OUT;
                end else if (r_j == 2'd3) begin
                    if (r_solve) begin
                        n_phase = PH_FORWARD;
                        n_i     = 2'd0;
                        n_state = ST_BASE;
                    end else begin
                        n_oidx  = '0;
                        n_state = ST_OUT;
                    end
                end else begin
                    n_phase = PH_UPPER;
                    n_i     = r_j + 2'd1;
                    n_state = ST_BASE;
                end
            end
            ST_OUT: begin
                // Load the next result word when the output register is free.
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oindex = r_oidx;
                    n_osing  = r_sing;
                    n_olast  = r_solve ? (r_oidx == 4'd3) : (r_oidx == 4'd15);
                    if (r_sing) begin
                        n_ovalue = '0;
                    end else if (outx > OMAX_A) begin
                        n_ovalue = 32'h7fff_ffff;
                    end else if (outx < OMIN_A) begin
                        n_ovalue = 32'h8000_0000;
                    end else begin
                        n_ovalue = outx[31:0];
                    end
                    n_oidx = r_oidx + 4'd1;
                    if (n_olast) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_phase  <= n_phase;
        r_j      <= n_j;
        r_i      <= n_i;
        r_k      <= n_k;
        r_solve  <= n_solve;
        r_sing   <= n_sing;
        r_neg    <= n_neg;
        r_acc    <= n_acc;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_pp     <= n_pp;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_lo     <= n_lo;
        r_prod   <= n_prod;
        r_md     <= n_md;
        r_rem    <= n_rem;
        r_dq     <= n_dq;
        r_dcnt   <= n_dcnt;
        r_oidx   <= n_oidx;
        r_oindex <= n_oindex;
        r_ovalue <= n_ovalue;
        r_osing  <= n_osing;
        r_olast  <= n_olast;
    end

    // Store writes.
    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            r_mat[{in_row, in_col}] <= wr_data;
        end
        if (rhs_we) begin
            r_rhs[in_row] <= wr_data;
        end
        if (fac_we) begin
            r_fac[fac_wa] <= wr_data;
        end
        if (vec_we) begin
            r_vec[r_i] <= wr_data;
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import lus_pkg::*;
;

    localparam longint VMAX   = 64'sd2147483647;
    localparam longint VMIN   = -64'sd2147483648;
    localparam longint unsigned MAGLIM = 64'd2147483648;
    localparam int     FRAC   = 16;
    localparam int     NUM_ITEMS = 120;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     DRAIN_CYCLES = 1500;

    // One expected result word.
    typedef struct {
        logic [3:0]  idx;
        logic [31:0] val;
        logic        sing;
        logic        last;
    } t_lu_word;

    // Tracks the loaded system, factors it and queues the words it should produce.
    class lu_scoreboard;
        longint   mat[16];
        longint   rhs[4];
        longint   fac[16];
        t_lu_word pending[$];
        int       errors;

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function longint clip(longint v);
            if (v > VMAX) return VMAX;
            if (v < VMIN) return VMIN;
            return v;
        endfunction

        function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function longint signed_mag(longint unsigned m, bit neg);
            longint v;
            if (m > MAGLIM) m = MAGLIM;
            v = neg ? -longint'(m) : longint'(m);
            return clip(v);
        endfunction

        // Product truncated toward zero, computed in 24-bit halves.
        function longint qmul(longint a, longint b);
            longint unsigned ma, mb, ah, al, bh, bl, hi, mid, lo, m;
            ma = magnitude(a);
            mb = magnitude(b);
            ah = ma >> 24;
            al = ma & 64'hFFFFFF;
            bh = mb >> 24;
            bl = mb & 64'hFFFFFF;
            hi = ah * bh;
            mid = ah * bl + al * bh;
            lo = al * bl;
            if (hi > (MAGLIM >> (48 - FRAC)) || mid > (MAGLIM >> (24 - FRAC)))
                m = MAGLIM;
            else
                m = (hi << (48 - FRAC)) + (mid << (24 - FRAC)) + (lo >> FRAC);
            return signed_mag(m, (a < 0) != (b < 0));
        endfunction

        // Quotient truncated toward zero; a zero divisor gives zero.
        function longint qdiv(longint n, longint d);
            longint unsigned mn, md, q, r;
            mn = magnitude(n);
            md = magnitude(d);
            if (md == 0) return 0;
            q = mn / md;
            r = mn % md;
            if (q > (MAGLIM >> FRAC)) begin
                q = MAGLIM;
            end else begin
                for (int i = 0; i < FRAC; i++) begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= md) begin
                        r = r - md;
                        q = q | 1;
                    end
                end
            end
            return signed_mag(q, (n < 0) != (d < 0));
        endfunction

        // Crout factorization; returns 0 on a zero pivot.
        function bit crout();
            longint acc;
            for (int j = 0; j < 4; j++) begin
                for (int i = j; i < 4; i++) begin
                    acc = mat[i*4+j];
                    for (int k = 0; k < j; k++) acc -= qmul(fac[i*4+k], fac[k*4+j]);
                    fac[i*4+j] = clip(acc);
                end
                if (fac[j*4+j] == 0) begin
                    foreach (fac[n]) fac[n] = 0;
                    return 0;
                end
                for (int i = j + 1; i < 4; i++) begin
                    acc = mat[j*4+i];
                    for (int k = 0; k < j; k++) acc -= qmul(fac[j*4+k], fac[k*4+i]);
                    fac[j*4+i] = qdiv(clip(acc), fac[j*4+j]);
                end
            end
            return 1;
        endfunction

        function void push_word(int idx, longint v, bit sing, bit last);
            t_lu_word w;
            w.idx  = idx[3:0];
            w.val  = v[31:0];
            w.sing = sing;
            w.last = last;
            pending.push_back(w);
        endfunction

        // Called for every accepted input word.
        function void note_input(logic [39:0] d, logic [1:0] u);
            t_mode  mode;
            int     row, col;
            longint v, acc;
            longint y[4], x[4];
            bit     ok;
            mode = t_mode'(u);
            row  = d[1:0];
            col  = d[3:2];
            v    = longint'($signed(d[35:4]));
            case (mode)
                MODE_LOAD_A: mat[row*4+col] = v;
                MODE_LOAD_B: rhs[row] = v;
                MODE_FACTOR: begin
                    ok = crout();
                    for (int i = 0; i < 16; i++)
                        push_word(i, ok ? fac[i] : 0, !ok, i == 15);
                end
                default: begin
                    ok = crout();
                    foreach (x[i]) begin
                        x[i] = 0;
                        y[i] = 0;
                    end
                    if (ok) begin
                        for (int i = 0; i < 4; i++) begin
                            acc = rhs[i];
                            for (int k = 0; k < i; k++) acc -= qmul(fac[i*4+k], y[k]);
                            y[i] = qdiv(clip(acc), fac[i*4+i]);
                        end
                        for (int i = 3; i >= 0; i--) begin
                            acc = y[i];
                            for (int k = i + 1; k < 4; k++) acc -= qmul(fac[i*4+k], x[k]);
                            x[i] = clip(acc);
                        end
                    end
                    for (int i = 0; i < 4; i++) push_word(i, x[i], !ok, i == 3);
                end
            endcase
        endfunction

        // Compares one output word against the oldest expectation.
        task check_word(logic [3:0] idx, logic [31:0] val, logic sing, logic last);
            t_lu_word w;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word index %0d value %h", idx, val));
                return;
            end
            w = pending.pop_front();
            if (idx !== w.idx) report($sformatf("index %0d, want %0d", idx, w.idx));
            if (val !== w.val)
                report($sformatf("index %0d value %h, want %h", w.idx, val, w.val));
            if (sing !== w.sing)
                report($sformatf("index %0d singular %b, want %b", w.idx, sing, w.sing));
            if (last !== w.last)
                report($sformatf("index %0d last %b, want %b", w.idx, last, w.last));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // row[1:0], col[3:2], value[35:4], zero[39:36]
    logic [39:0] i_s_axis_tdata = '0;
    // mode[1:0]
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // index[3:0], result_value[35:4], zero[39:36]
    logic [39:0] o_m_axis_tdata;
    // singular[0]
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    lu_scoreboard lu_sb = new();
    int  cycles = 0;
    int  words_out = 0;
    int  items_sent = 0;
    int  hold_left = 0;
    int  sink_gap = 0;
    bit  hold_done = 1'b0;
    bit  calm = 1'b0;

    lu_solve_4x4 uut (.*);

    // Clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[lu_solve_4x4] ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result sink: checks words, stalls at random and once holds off for a long time.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            lu_sb.check_word(o_m_axis_tdata[3:0], o_m_axis_tdata[35:4],
                             o_m_axis_tuser, o_m_axis_tlast);
            words_out <= words_out + 1;
            if (!hold_done && words_out >= 40) begin
                hold_done = 1'b1;
                hold_left = 3000;
            end
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap = sink_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            sink_gap = pick_gap();
            i_m_axis_tready <= (sink_gap == 0);
        end
    end

    // Offers one input word and waits until it is taken.
    task automatic send_word(t_mode mode, int row, int col, logic [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, val, col[1:0], row[1:0]};
        i_s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        lu_sb.note_input(i_s_axis_tdata, i_s_axis_tuser);
        if (mode == MODE_SOLVE || mode == MODE_FACTOR) items_sent++;
        else items_sent++;
    endtask

    function logic [31:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 32'($urandom_range(0, 393216)) - 32'd196608;
        if (r < 80) return $urandom();
        if (r < 87) return 32'h7FFFFFFF;
        if (r < 94) return 32'h80000000;
        return 32'h0;
    endfunction

    initial begin
        int nloads;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Well-conditioned matrix, rhs including both extremes; col is ignored on rhs loads.
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send_word(MODE_LOAD_A, i, j, (i == j) ? 32'h00020000 : 32'h00008000);
        send_word(MODE_LOAD_B, 0, 3, 32'h00010000);
        send_word(MODE_LOAD_B, 1, 2, 32'hFFFF0000);
        send_word(MODE_LOAD_B, 2, 1, 32'h7FFFFFFF);
        send_word(MODE_LOAD_B, 3, 0, 32'h80000000);
        send_word(MODE_SOLVE, 0, 0, 32'h0);
        send_word(MODE_FACTOR, 3, 3, 32'hFFFFFFFF);
        // Zero pivot in the first column.
        send_word(MODE_LOAD_A, 0, 0, 32'h0);
        send_word(MODE_FACTOR, 0, 0, 32'h0);
        send_word(MODE_SOLVE, 0, 0, 32'h0);
        // Last row equal to the third one: the last pivot comes out zero.
        send_word(MODE_LOAD_A, 0, 0, 32'h00020000);
        for (int j = 0; j < 4; j++)
            send_word(MODE_LOAD_A, 3, j, (j == 2) ? 32'h00020000 : 32'h00008000);
        send_word(MODE_SOLVE, 0, 0, 32'h0);
        send_word(MODE_FACTOR, 0, 0, 32'h0);

        // Random sequences: a few loads followed by a solve or a factor request.
        while (items_sent < NUM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                for (int i = 0; i < 4; i++)
                    send_word(MODE_LOAD_A, i, i,
                              32'($urandom_range(65536, 524288))
                              ^ {1'($urandom_range(0, 1)), 31'h0});
            end
            nloads = $urandom_range(0, 6);
            for (int n = 0; n < nloads; n++)
                send_word(($urandom_range(0, 9) < 7) ? MODE_LOAD_A : MODE_LOAD_B,
                          $urandom_range(0, 3), $urandom_range(0, 3), rand_value());
            send_word(($urandom_range(0, 9) < 6) ? MODE_SOLVE : MODE_FACTOR,
                      $urandom_range(0, 3), $urandom_range(0, 3), $urandom());
        end
        i_s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        wait (lu_sb.pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (lu_sb.errors == 0)
            $display("[lu_solve_4x4] OK");
        else
            $display("[lu_solve_4x4] ERROR");
        $finish;
    end

endmodule

FILE: lu_solve_4x4.f
hw/rtl/lus_pkg.sv
hw/rtl/lu_solve_4x4.sv
tb/sv/tb_top.sv
